>>> rtl/rfft_pkg.sv
// Shared constants and types for the resolver frame fault tracker.
package rfft_pkg;

	// Frame layout and field widths.
	localparam int FRAME_W   = 16;
	localparam int ANGLE_W   = 12;
	localparam int ANGLE_LSB = 4;
	localparam int COEFF_W   = 16;
	localparam int RATE_W    = 16;
	localparam int COUNT_W   = 32;

	// Fault kinds, in flag-bit order.
	localparam int FAULT_KINDS = 4;
	localparam int F_PARITY    = 0;
	localparam int F_TRACKING  = 1;
	localparam int F_DEGRADE   = 2;
	localparam int F_SIG_LOSS  = 3;

	// Marker bits inside the frame.
	localparam int BIT_POSITION = 3;
	localparam int BIT_DOS_N    = 2;
	localparam int BIT_LOT_N    = 1;

	// Reset value of the filter coefficient.
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd7;

	// Output payload width, padded to whole bytes.
	localparam int OUT_FIELDS_W = ANGLE_W + 2 + FAULT_KINDS
		+ FAULT_KINDS * COUNT_W + FAULT_KINDS * RATE_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Decoded view of one frame.
	typedef struct packed {
		logic                   position;
		logic [FAULT_KINDS-1:0] hits;
	} frame_info_t;

endpackage

>>> rtl/rfft_decode.sv
// Frame decoder: position marker, parity check and fault flags.
module rfft_decode
	import rfft_pkg::*;
(
	input  logic [FRAME_W-1:0] frame,
	output frame_info_t        info
);

	logic dos;
	logic lot;
	logic los;
	logic parity_err;

	// Both DOS and LOT low report loss of signal instead of tracking loss or degradation.
	always_comb begin
		dos        = ~frame[BIT_DOS_N];
		lot        = ~frame[BIT_LOT_N];
		los        = dos & lot;
		parity_err = ~(^frame);
		info.position = frame[BIT_POSITION];
		info.hits     = '0;
		if (frame[BIT_POSITION]) begin
			info.hits[F_PARITY]   = parity_err;
			info.hits[F_TRACKING] = lot & ~los;
			info.hits[F_DEGRADE]  = dos & ~los;
			info.hits[F_SIG_LOSS] = los;
		end
	end

endmodule

>>> rtl/rfft_rate.sv
// One low-pass rate lane: moves the rate toward full scale or zero.
module rfft_rate
	import rfft_pkg::*;
(
	input  logic [RATE_W-1:0]  rate,
	input  logic               hit,
	input  logic [COEFF_W-1:0] coeff,
	output logic [RATE_W-1:0]  rate_next
);

	logic [RATE_W-1:0]          span;
	logic [RATE_W+COEFF_W-1:0]  prod;
	logic [RATE_W-1:0]          step_dn;
	logic [RATE_W-1:0]          step_up;

	// Distance to the target times the coefficient; floor toward the target
	// when rising, round the magnitude up when falling.
	always_comb begin
		span    = hit ? ~rate : rate;
		prod    = {{COEFF_W{1'b0}}, span} * {{RATE_W{1'b0}}, coeff};
		step_dn = prod[RATE_W+COEFF_W-1:COEFF_W];
		step_up = step_dn + {{(RATE_W-1){1'b0}}, |prod[COEFF_W-1:0]};
		if (hit) begin
			rate_next = rate + step_dn;
		end else begin
			rate_next = rate - step_up;
		end
	end

endmodule

>>> rtl/resolver_frame_fault_tracker.sv
// Top level of the resolver frame fault tracker.
// Takes one 16-bit converter frame per clock cycle while the output is not
// stalled and returns one result per frame. A request is captured in an input
// register, then decoded and folded into the angle, counter and rate registers,
// which together form the result register, once that register is free or being
// taken. The sustained rate is one frame per cycle while m_tready stays high.
// The four rate lanes each use one 16x16 multiplier in the update stage. The
// user must write the filter coefficient through cfg_we/cfg_wdata only while
// no frame is in flight; the block itself does not enforce this.
module resolver_frame_fault_tracker
	import rfft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: filter coefficient.
	input  logic                  cfg_we,
	input  logic [COEFF_W-1:0]    cfg_wdata,
	// Input stream. s_tdata: raw_frame[15:0].
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [FRAME_W-1:0]    s_tdata,
	// Output stream. m_tdata from bit 0 up: angle_code[11:0], angle_updated,
	// is_position, fault_flags[3:0], parity_error_count, tracking_loss_count,
	// degradation_count, signal_loss_count (32 each), parity_error_rate,
	// tracking_loss_rate, degradation_rate, signal_loss_rate (16 each), zero pad.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [COEFF_W-1:0]     coeff_q;
	logic                   valid_s1;
	logic [FRAME_W-1:0]     frame_s1;
	logic                   out_valid_q;
	logic                   advance;
	frame_info_t            info;
	logic [ANGLE_W-1:0]     angle_q;
	logic                   updated_q;
	logic                   position_q;
	logic [FAULT_KINDS-1:0] flags_q;
	logic [COUNT_W-1:0]     count_q [FAULT_KINDS];
	logic [RATE_W-1:0]      rate_q  [FAULT_KINDS];
	logic [RATE_W-1:0]      rate_next [FAULT_KINDS];

	// Coefficient register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RESET;
		end else if (cfg_we) begin
			coeff_q <= cfg_wdata;
		end
	end

	// The update stage moves when the result register is free or being taken.
	assign advance  = ~out_valid_q | m_tready;
	assign s_tready = ~valid_s1 | advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			frame_s1 <= s_tdata;
		end
	end

	// Decode and rate lanes.
	rfft_decode u_decode (
		.frame (frame_s1),
		.info  (info)
	);

	for (genvar k = 0; k < FAULT_KINDS; k++) begin : g_rate
		rfft_rate u_rate (
			.rate      (rate_q[k]),
			.hit       (info.hits[k]),
			.coeff     (coeff_q),
			.rate_next (rate_next[k])
		);
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Tracked state doubles as the result register: it only changes when the
	// held result is free or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= '0;
			updated_q  <= 1'b0;
			position_q <= 1'b0;
			flags_q    <= '0;
			for (int i = 0; i < FAULT_KINDS; i++) begin
				count_q[i] <= '0;
				rate_q[i]  <= '0;
			end
		end else if (advance && valid_s1) begin
			position_q <= info.position;
			flags_q    <= info.hits;
			updated_q  <= info.position & ~(|info.hits);
			if (info.position && !(|info.hits)) begin
				angle_q <= frame_s1[ANGLE_LSB +: ANGLE_W];
			end
			if (info.position) begin
				for (int i = 0; i < FAULT_KINDS; i++) begin
					rate_q[i] <= rate_next[i];
					if (info.hits[i]) begin
						count_q[i] <= count_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// Result packing, highest field first.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
		rate_q[F_SIG_LOSS], rate_q[F_DEGRADE], rate_q[F_TRACKING], rate_q[F_PARITY],
		count_q[F_SIG_LOSS], count_q[F_DEGRADE], count_q[F_TRACKING], count_q[F_PARITY],
		flags_q, position_q, updated_q, angle_q
	};

`ifndef ASSERT_OFF
	// A stored angle means a fault-free position frame.
	a_update_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && updated_q |-> position_q && flags_q == '0)
		else $error("angle stored on a faulty or non-position frame");

	// Faults are only reported for position frames.
	a_flags_position: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && flags_q != '0 |-> position_q)
		else $error("fault flagged on a non-position frame");

	// Loss of signal excludes tracking loss and degradation.
	a_los_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q[F_SIG_LOSS] |-> !flags_q[F_TRACKING] && !flags_q[F_DEGRADE])
		else $error("signal loss reported together with DOS or LOT");

	// The parity counter and rate hold while the result register is stalled.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(count_q[F_PARITY]) && $stable(rate_q[F_PARITY]))
		else $error("tracked state changed during a stall");
`endif

endmodule

>>> sim/fault_report_checker.sv
// Predicts and checks every result of the resolver frame fault tracker.
module fault_report_checker
	import rfft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COEFF_W-1:0]    cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [FRAME_W-1:0]    s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int unsigned           outstanding,
	output int unsigned           mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [RATE_W-1:0] RATE_FULL = '1;

	// One result, laid out so that it maps directly onto m_tdata from bit 0 up.
	typedef struct packed {
		logic [FAULT_KINDS-1:0][RATE_W-1:0]  rates;
		logic [FAULT_KINDS-1:0][COUNT_W-1:0] counts;
		logic [FAULT_KINDS-1:0]              flags;
		logic                                is_position;
		logic                                angle_updated;
		logic [ANGLE_W-1:0]                  angle;
	} fault_report_t;

	string count_names [FAULT_KINDS] = '{"parity_error_count", "tracking_loss_count",
		"degradation_count", "signal_loss_count"};
	string rate_names [FAULT_KINDS] = '{"parity_error_rate", "tracking_loss_rate",
		"degradation_rate", "signal_loss_rate"};

	// Tracker state as the testbench sees it, plus the filter coefficient.
	logic [COEFF_W-1:0]     coeff;
	fault_report_t          tracker;
	fault_report_t          expected_reports [$];
	fault_report_t          want;
	fault_report_t          got;
	logic [OUT_DATA_W-1:0]  pad_bits;
	int unsigned            error_tally = 0;

	// First-order low-pass step toward full scale or zero, floor rounding.
	function automatic logic [RATE_W-1:0] filter_rate(input logic [RATE_W-1:0] r,
		input logic hit, input logic [COEFF_W-1:0] c);
		logic [31:0] prod;
		if (hit) begin
			prod = {16'd0, RATE_FULL - r} * {16'd0, c};
			return r + prod[31:16];
		end
		// Rounding the magnitude up gives the floor of the negative step.
		prod = {16'd0, r} * {16'd0, c} + 32'h0000_FFFF;
		return r - prod[31:16];
	endfunction

	// Folds one frame into the tracker state and returns the new report.
	function automatic fault_report_t next_report(input fault_report_t prev,
		input logic [FRAME_W-1:0] frame, input logic [COEFF_W-1:0] c);
		fault_report_t          r;
		logic [FAULT_KINDS-1:0] hits;
		logic                   dos;
		logic                   lot;
		int                     k;
		r = prev;
		r.angle_updated = 1'b0;
		r.is_position   = frame[BIT_POSITION];
		r.flags         = '0;
		if (!frame[BIT_POSITION]) begin
			return r;
		end
		dos = !frame[BIT_DOS_N];
		lot = !frame[BIT_LOT_N];
		hits[F_PARITY]   = ~^frame;
		// Both markers low means loss of signal, not tracking loss or degradation.
		hits[F_SIG_LOSS] = dos && lot;
		hits[F_TRACKING] = lot && !dos;
		hits[F_DEGRADE]  = dos && !lot;
		for (k = 0; k < FAULT_KINDS; k++) begin
			if (hits[k]) begin
				r.counts[k] = r.counts[k] + 1'b1;
			end
			r.rates[k] = filter_rate(r.rates[k], hits[k], c);
		end
		r.flags = hits;
		if (hits == '0) begin
			r.angle         = frame[FRAME_W-1:ANGLE_LSB];
			r.angle_updated = 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			error_tally++;
		end
	endtask

	// Watch both channels; results are retired before new requests are queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff   = COEFF_RESET;
			tracker = '0;
			expected_reports.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				coeff = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$error("result with no request pending: %h", m_tdata);
					error_tally++;
				end else begin
					want     = expected_reports.pop_front();
					got      = fault_report_t'(m_tdata[OUT_FIELDS_W-1:0]);
					pad_bits = m_tdata >> OUT_FIELDS_W;
					check_field("angle_code", 64'(want.angle), 64'(got.angle));
					check_field("angle_updated", 64'(want.angle_updated),
						64'(got.angle_updated));
					check_field("is_position", 64'(want.is_position), 64'(got.is_position));
					check_field("fault_flags", 64'(want.flags), 64'(got.flags));
					for (int k = 0; k < FAULT_KINDS; k++) begin
						check_field(count_names[k], 64'(want.counts[k]), 64'(got.counts[k]));
						check_field(rate_names[k], 64'(want.rates[k]), 64'(got.rates[k]));
					end
					check_field("padding", 64'd0, pad_bits[63:0]);
				end
			end
			if (s_tvalid && s_tready) begin
				tracker = next_report(tracker, s_tdata, coeff);
				expected_reports.push_back(tracker);
			end
			outstanding <= expected_reports.size();
		end
		mismatches <= error_tally;
	end

endmodule

>>> sim/resolver_frame_fault_tracker_tb.sv
// Stimulus and verdict for the resolver frame fault tracker testbench.
module resolver_frame_fault_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfft_pkg::*;

	localparam int PHASES        = 7;
	localparam int RANDOM_FRAMES = 833;

	typedef enum logic [2:0] {
		PAT_CLEAN, PAT_PARITY, PAT_DOS, PAT_LOT, PAT_LOS, PAT_NOISE
	} frame_pattern_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [COEFF_W-1:0]    cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [FRAME_W-1:0]    s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int unsigned           outstanding;
	int unsigned           mismatches;

	int  sender_gap_pct     = 25;
	int  receiver_stall_pct = 25;
	bit  calm               = 1'b0;
	int  frames_sent        = 0;
	int  position_sent      = 0;
	int  coeff_writes       = 0;
	int  target;
	int  run_len;
	frame_pattern_t pattern;
	logic [COEFF_W-1:0] phase_coeffs [PHASES];

	// Edge cases: both markers, all ones and zeros, each fault alone and mixed.
	logic [FRAME_W-1:0] directed_frames [] = '{
		16'h0000, 16'hFFF7, 16'h0007, 16'h000E, 16'hFFFE, 16'hFFFF,
		16'h001A, 16'h000A, 16'h001C, 16'h000C, 16'h0008, 16'hFFF9,
		16'hFFFA, 16'h123E, 16'h8001, 16'h5A5F, 16'hABCF
	};

	resolver_frame_fault_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	fault_report_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver stalls in short random bursts, none in the calm stretch.
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < receiver_stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Builds a frame of the given kind with random content elsewhere.
	function automatic logic [FRAME_W-1:0] make_frame(input frame_pattern_t p);
		logic [FRAME_W-1:0] f;
		f = FRAME_W'($urandom);
		case (p)
			PAT_CLEAN, PAT_PARITY: begin
				f[3:1] = 3'b111;
				f[0]   = 1'b0;
				f[0]   = (p == PAT_CLEAN) ? ~^f : ^f;
			end
			PAT_DOS: begin
				f[3:1] = 3'b101;
			end
			PAT_LOT: begin
				f[3:1] = 3'b110;
			end
			PAT_LOS: begin
				f[3:1] = 3'b100;
			end
			default: begin
			end
		endcase
		return f;
	endfunction

	function automatic frame_pattern_t pick_pattern();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return PAT_CLEAN;
		if (r < 50) return PAT_PARITY;
		if (r < 62) return PAT_DOS;
		if (r < 74) return PAT_LOT;
		if (r < 86) return PAT_LOS;
		return PAT_NOISE;
	endfunction

	// Offers one frame, with an optional gap first, and waits for acceptance.
	task automatic send_frame(input logic [FRAME_W-1:0] f);
		if (!calm && $urandom_range(0, 99) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		do @(posedge clk); while (!s_tready);
		frames_sent++;
		if (f[BIT_POSITION]) begin
			position_sent++;
		end
	endtask

	// Holds off new requests until every pending result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_coeff(input logic [COEFF_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		coeff_writes++;
	endtask

	// Main sequence: reset, directed frames, then phases of random bursts.
	initial begin
		phase_coeffs[0] = 16'hFFFF;
		phase_coeffs[1] = 16'd1;
		phase_coeffs[2] = 16'd0;
		phase_coeffs[3] = 16'h8000;
		phase_coeffs[4] = COEFF_W'($urandom_range(2, 65534));
		phase_coeffs[5] = COEFF_W'($urandom_range(2, 4095));
		phase_coeffs[6] = COEFF_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_frames[i]) begin
			send_frame(directed_frames[i]);
		end
		drain_results();

		position_sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			write_coeff(phase_coeffs[p]);
			sender_gap_pct     = $urandom_range(0, 2) * 25;
			receiver_stall_pct = $urandom_range(0, 2) * 25;
			if (p == PHASES - 1) begin
				calm = 1'b1;
			end
			target = frames_sent + RANDOM_FRAMES / PHASES;
			while (frames_sent < target) begin
				pattern = pick_pattern();
				run_len = $urandom_range(1, 24);
				if (run_len > target - frames_sent) begin
					run_len = target - frames_sent;
				end
				repeat (run_len) send_frame(make_frame(pattern));
			end
			drain_results();
		end

		// Let any stray result surface before the verdict.
		repeat (10) @(posedge clk);

		$display("Sent %0d frames (%0d random position frames) over %0d coefficient",
			frames_sent, position_sent, coeff_writes + 1);
		$display("settings, from zero and one up to full scale, with random stalls.");
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
